@@ rtl/sai_pkg.sv @@
// sorted list insert: shared types and constants
// request payload structs and the controller state type; no dependencies
package sai_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic                       command;
    logic signed [VALUE_W-1:0]  value;
  } sai_in_t;

  typedef struct packed {
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  entry;
    logic                       last;
    logic                       refused;
  } sai_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } sai_state_t;

endpackage

@@ rtl/sai_ram.sv @@
// generic simple dual port ram: one write port, one registered read port
// read data holds while read enable is low; no dependencies
module sai_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/sorted_array_insert_top.sv @@
// Sorted list insert: an accepted insert reads the list head from the ram, then its first
// result is registered in the output register. Throughput: one result per cycle while out_ready
// is high; an insert on a list of n entries emits n+1 results (n when refused as full) as the
// single ram read port walks the list once, a clear only empties the list, and no request is
// taken until a walk ends. Reset (synchronous, rst_n low) empties the list; the ram contents are
// not cleared since only written entries are ever emitted. depends on sai_pkg and sai_ram
module sorted_array_insert_top
  import sai_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sai_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sai_out_t out_data
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  sai_state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] end_idx_r, end_idx_nxt;
  logic          placed_r, placed_nxt;
  logic          refused_r, refused_nxt;
  logic signed [VALUE_W-1:0] ins_val_r, ins_val_nxt;
  logic signed [VALUE_W-1:0] carry_r, carry_nxt;
  logic          out_valid_r, out_valid_nxt;
  sai_out_t      out_data_r, out_data_nxt;

  logic                      in_acc;
  logic                      is_full;
  logic                      step;
  logic                      at_end;
  logic                      place;
  logic signed [VALUE_W-1:0] old_val;
  logic signed [VALUE_W-1:0] new_val;

  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic                      ram_re;
  logic [IW-1:0]             ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;

  sai_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (new_val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_acc  = in_valid && in_ready;
  assign is_full = (count_r == CW'(CAPACITY));
  assign old_val = $signed(ram_rdata);

  // one list element per cycle whenever the output register can take it
  assign step   = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  assign at_end = (k_r == end_idx_r);

  // new value goes before the first entry that is not below it, or at the tail
  assign place = !refused_r && !placed_r && (at_end || !(old_val < ins_val_r));

  always_comb begin
    if (refused_r) begin
      new_val = old_val;
    end else if (placed_r) begin
      new_val = carry_r;
    end else if (place) begin
      new_val = ins_val_r;
    end else begin
      new_val = old_val;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.command == CMD_INSERT) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step && at_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    count_nxt     = count_r;
    k_nxt         = k_r;
    end_idx_nxt   = end_idx_r;
    placed_nxt    = placed_r;
    refused_nxt   = refused_r;
    ins_val_nxt   = ins_val_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.command == CMD_CLEAR) begin
            count_nxt = '0;
          end else begin
            // start the walk at the head of the list
            refused_nxt = is_full;
            end_idx_nxt = is_full ? IW'(count_r - CW'(1)) : IW'(count_r);
            ins_val_nxt = in_data.value;
            placed_nxt  = 1'b0;
            k_nxt       = '0;
            ram_re      = 1'b1;
            ram_raddr   = '0;
          end
        end
      end
      ST_RUN: begin
        if (step) begin
          ram_we                = !refused_r;
          out_valid_nxt         = 1'b1;
          out_data_nxt.position = POS_W'(k_r);
          out_data_nxt.entry    = new_val;
          out_data_nxt.last     = at_end;
          out_data_nxt.refused  = refused_r;
          if (placed_r || place) begin
            carry_nxt  = old_val;
            placed_nxt = 1'b1;
          end
          if (at_end) begin
            if (!refused_r) begin
              count_nxt = count_r + CW'(1);
            end
          end else begin
            k_nxt     = k_r + IW'(1);
            ram_re    = 1'b1;
            ram_raddr = k_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    end_idx_r  <= end_idx_nxt;
    placed_r   <= placed_nxt;
    refused_r  <= refused_nxt;
    ins_val_r  <= ins_val_nxt;
    carry_r    <= carry_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ dv/sorted_array_insert_top_tb.sv @@
`timescale 1ns / 100ps
// testbench for sorted_array_insert_top: directed and random insert/clear requests
// checked against an in-bench sorted list predictor; depends on sai_pkg and the rtl
module sorted_array_insert_top_tb;
  import sai_pkg::*;

  localparam int unsigned LIST_DEPTH      = 64;
  localparam int          TARGET_REQUESTS = 470;
  localparam int          SETTLE_CYCLES   = LIST_DEPTH + 8;
  localparam int          STALL_LIMIT     = 3000;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          MAX_REPORTS     = 10;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VALUE_ONE = 32'sh0001_0000;

  typedef enum int {
    VS_FULL,
    VS_NARROW,
    VS_EXTREME,
    VS_WHOLE
  } value_style_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  sai_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sai_out_t out_data;

  // predicted list contents and the results still owed by the block
  logic signed [VALUE_W-1:0] list_vals [LIST_DEPTH];
  int                        list_len = 0;
  sai_out_t                  expected_results [$];

  int mismatch_count = 0;
  int requests_sent  = 0;

  // sender and receiver pacing controls
  bit tx_gaps_on    = 1'b1;
  int tx_burst_left = 0;
  bit rx_stalls_on  = 1'b1;
  int rx_hold_req   = 0;
  int rx_hold_left  = 0;
  int rx_phase_left = 0;
  bit rx_ready_phase = 1'b0;

  sorted_array_insert_top #(
    .CAPACITY(LIST_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // push one result per stored entry, front to back
  task automatic queue_list_results(input logic refused);
    sai_out_t res;
    int       k;
    for (k = 0; k < list_len; k++) begin
      res.position = POS_W'(k);
      res.entry    = list_vals[k];
      res.last     = (k == list_len - 1);
      res.refused  = refused;
      expected_results.push_back(res);
    end
  endtask

  // sorted list predictor, run on every accepted request
  task automatic predict_request(input sai_in_t req);
    int slot;
    int k;
    if (req.command == CMD_CLEAR) begin
      list_len = 0;
      return;
    end
    if (list_len >= LIST_DEPTH) begin
      queue_list_results(1'b1);
      return;
    end
    // new value goes after every strictly smaller entry
    slot = 0;
    while (slot < list_len && $signed(list_vals[slot]) < $signed(req.value)) slot++;
    for (k = list_len; k > slot; k--) list_vals[k] = list_vals[k - 1];
    list_vals[slot] = req.value;
    list_len++;
    queue_list_results(1'b0);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value(input value_style_t style);
    int pick;
    case (style)
      VS_NARROW: return $signed($urandom_range(0, 16)) - 8;
      VS_WHOLE:  return ($signed($urandom_range(0, 200)) - 100) <<< 16;
      VS_EXTREME: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0:       return VALUE_MIN;
          1:       return VALUE_MAX;
          2:       return VALUE_MIN + 1;
          3:       return VALUE_MAX - 1;
          4:       return -1;
          default: return 0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // bursts of requests with random gaps between them
  task automatic sender_pace();
    int gap;
    if (!tx_gaps_on) return;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
    end else begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
      tx_burst_left = $urandom_range(0, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // offer one request and hold it until accepted
  task automatic send_request(input logic cmd, input logic signed [VALUE_W-1:0] value);
    sai_in_t req;
    req.command = cmd;
    req.value   = value;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_request(req);
    requests_sent++;
    sender_pace();
  endtask

  task automatic send_insert(input logic signed [VALUE_W-1:0] value);
    send_request(CMD_INSERT, value);
  endtask

  task automatic send_clear();
    send_request(CMD_CLEAR, $urandom);
  endtask

  // stop sending and wait for every owed result, then let the block settle
  task automatic drain_expected();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // empty list, smallest, equal values, extremes, clear on empty and non-empty lists
  task automatic test_directed_cases();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    send_clear();
    send_insert(0);
    send_insert(VALUE_MAX);
    send_insert(VALUE_MIN);
    send_insert(0);
    send_insert(1);
    send_insert(-1);
    send_insert(VALUE_MIN);
    send_insert(VALUE_MAX);
    send_insert(VALUE_ONE);
    send_insert(-VALUE_ONE);
    send_insert(32'sh5555_aaaa);
    send_insert(32'sh2aaa_5555);
    send_clear();
    send_insert(5);
    send_insert(5);
    send_clear();
    send_clear();
    send_insert(VALUE_MIN);
  endtask

  // fill to capacity, then inserts on a full list are refused
  task automatic test_full_list();
    int n;
    send_clear();
    for (n = 0; n < LIST_DEPTH; n++)
      send_insert(random_value(($urandom_range(0, 1) == 0) ? VS_NARROW : VS_FULL));
    send_insert(VALUE_MIN);
    send_insert(VALUE_MAX);
    send_insert(random_value(VS_FULL));
    send_clear();
    send_insert(random_value(VS_FULL));
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_output_backpressure();
    int n;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    send_clear();
    rx_hold_req = HOLD_CYCLES;
    for (n = 0; n < 12; n++) send_insert(random_value(VS_WHOLE));
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // sender goes quiet until every result is in, then resumes
  task automatic test_pause_and_resume();
    int n;
    for (n = 0; n < 4; n++) send_insert(random_value(VS_NARROW));
    drain_expected();
    for (n = 0; n < 4; n++) send_insert(random_value(VS_NARROW));
  endtask

  // mostly clear-then-fill sequences with random content, some noise
  task automatic test_random_sequences();
    int           seq_kind;
    int           fill;
    int           n;
    int           seq_idx;
    value_style_t style;
    seq_idx = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      seq_kind     = $urandom_range(0, 9);
      style        = value_style_t'($urandom_range(0, 3));
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      if (seq_kind == 9) begin
        // noise: random commands, no list discipline
        for (n = 0; n < 6; n++) begin
          if ($urandom_range(0, 3) == 0) send_clear();
          else send_insert(random_value(style));
        end
      end else begin
        if (seq_kind < 6) fill = $urandom_range(1, 12);
        else if (seq_kind < 8) fill = $urandom_range(13, 40);
        else fill = $urandom_range(LIST_DEPTH, LIST_DEPTH + 3);
        if ($urandom_range(0, 4) != 0) send_clear();
        for (n = 0; n < fill; n++) begin
          // occasional stray clear breaks the sequence
          if ($urandom_range(0, 39) == 0) send_clear();
          else send_insert(random_value(style));
        end
      end
      seq_idx++;
      if (seq_idx % 7 == 0) drain_expected();
    end
  endtask

  // receiver: long hold-off on request, else ready/stall runs of its own
  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (!rx_stalls_on) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_phase_left == 0) begin
        rx_ready_phase = !rx_ready_phase;
        rx_phase_left  = rx_ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end
      rx_phase_left--;
      out_ready <= rx_ready_phase;
    end
  end

  // result checker against the oldest owed result
  always @(posedge clk) begin
    sai_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result pos=%0d entry=%0d last=%0b refused=%0b", $time,
                   out_data.position, out_data.entry, out_data.last, out_data.refused);
      end else begin
        want = expected_results.pop_front();
        if (out_data.position !== want.position || out_data.entry !== want.entry ||
            out_data.last !== want.last || out_data.refused !== want.refused) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: expected pos=%0d entry=%0d last=%0b refused=%0b", $time,
                     want.position, want.entry, want.last, want.refused);
            $display("%0t:      got pos=%0d entry=%0d last=%0b refused=%0b", $time,
                     out_data.position, out_data.entry, out_data.last, out_data.refused);
          end
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: timeout, nothing moved for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_list();
    test_output_backpressure();
    test_pause_and_resume();
    test_random_sequences();
    drain_expected();
    if (expected_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
